### src/servo_status_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// servo_status_frame_receiver_macros
// Assertion helpers used by the checker file; the bodies use the clk and
// rst_n of the module that expands them.
// ----------------------------------------------------------------------------
`ifndef SERVO_STATUS_FRAME_RECEIVER_MACROS_SVH
`define SERVO_STATUS_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ssfr_pkg.sv
// ----------------------------------------------------------------------------
// ssfr_pkg
// Types, codes and helpers of the servo status frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssfr_pkg;

  // Input commands
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_ARM  = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_CHECKSUM = 3'd1;
  localparam logic [2:0] STAT_WRONG_ID = 3'd2;
  localparam logic [2:0] STAT_SHORT    = 3'd3;
  localparam logic [2:0] STAT_TIMEOUT  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_SERVO_ID = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_KEEP_LEN = 2'd2;

  localparam logic [7:0]  HEADER_BYTE    = 8'hFF;
  localparam logic [7:0]  MIN_LENGTH     = 8'd2;
  localparam logic [15:0] TICKS_MAX      = 16'hFFFF;
  localparam logic [7:0]  RST_SERVO_ID   = 8'd1;
  localparam logic [15:0] RST_TIMEOUT    = 16'd1000;
  localparam logic [7:0]  RST_KEEP_LEN   = 8'd8;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] index;
    logic [2:0] status;
    logic [7:0] servo_error;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  servo_id;
    logic [15:0] timeout_ticks;
    logic [7:0]  keep_len;
  } cfg_t;

  function automatic out_item_t mk_status(input logic [2:0] st, input logic [7:0] err);
    out_item_t r;
    r.data        = 8'd0;
    r.index       = 8'd0;
    r.status      = st;
    r.servo_error = err;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage

### src/ssfr_parser.sv
// ----------------------------------------------------------------------------
// ssfr_parser
// Frame state and single-cycle step logic of the status reply parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssfr_parser
  import ssfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_item_t res
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HUNT    = 3'd1;
  localparam logic [2:0] PH_ID      = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_ERR     = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_CHECK   = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  err_byte_r, err_byte_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  pay_idx_r, pay_idx_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  logic [15:0] ticks_inc;
  logic [7:0]  idx_inc;
  logic [7:0]  b;

  assign b         = item.rx_byte;
  assign ticks_inc = (ticks_r == TICKS_MAX) ? ticks_r : ticks_r + 16'd1;
  assign idx_inc   = pay_idx_r + 8'd1;

  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    frame_len_nxt = frame_len_r;
    err_byte_nxt  = err_byte_r;
    sum_nxt       = sum_r;
    pay_idx_nxt   = pay_idx_r;
    ticks_nxt     = ticks_r;
    res_valid     = 1'b0;
    res           = '0;
    if (step_en) begin
      case (item.command)
        CMD_ARM: begin
          phase_nxt     = PH_HUNT;
          hdr_cnt_nxt   = 2'd0;
          frame_len_nxt = 8'd0;
          err_byte_nxt  = 8'd0;
          sum_nxt       = 8'd0;
          pay_idx_nxt   = 8'd0;
          ticks_nxt     = 16'd0;
        end
        CMD_TICK: begin
          if (phase_r != PH_IDLE) begin
            ticks_nxt = ticks_inc;
            if (ticks_inc >= cfg.timeout_ticks) begin
              res_valid = 1'b1;
              res       = mk_status(STAT_TIMEOUT, err_byte_r);
              phase_nxt = PH_IDLE;
            end
          end
        end
        CMD_BYTE: begin
          if (phase_r != PH_IDLE) begin
            ticks_nxt = 16'd0;
            case (phase_r)
              PH_HUNT: begin
                if (b == HEADER_BYTE) begin
                  hdr_cnt_nxt = hdr_cnt_r + 2'd1;
                  if (hdr_cnt_r + 2'd1 >= 2'd2) begin
                    phase_nxt = PH_ID;
                  end
                end else begin
                  hdr_cnt_nxt = 2'd0;
                end
              end
              PH_ID: begin
                // running sum starts at the id, so sum_r holds the id at PH_LEN
                sum_nxt   = b;
                phase_nxt = PH_LEN;
              end
              PH_LEN: begin
                frame_len_nxt = b;
                sum_nxt       = sum_r + b;
                if (sum_r != cfg.servo_id) begin
                  res_valid = 1'b1;
                  res       = mk_status(STAT_WRONG_ID, 8'd0);
                  phase_nxt = PH_IDLE;
                end else if (b < MIN_LENGTH) begin
                  res_valid = 1'b1;
                  res       = mk_status(STAT_SHORT, 8'd0);
                  phase_nxt = PH_IDLE;
                end else begin
                  phase_nxt = PH_ERR;
                end
              end
              PH_ERR: begin
                err_byte_nxt = b;
                sum_nxt      = sum_r + b;
                pay_idx_nxt  = 8'd0;
                phase_nxt    = (frame_len_r == MIN_LENGTH) ? PH_CHECK : PH_PAYLOAD;
              end
              PH_PAYLOAD: begin
                sum_nxt = sum_r + b;
                if (pay_idx_r < cfg.keep_len) begin
                  res_valid       = 1'b1;
                  res.data        = b;
                  res.index       = pay_idx_r;
                  res.status      = STAT_OK;
                  res.servo_error = err_byte_r;
                  res.last        = 1'b0;
                end
                pay_idx_nxt = idx_inc;
                if (idx_inc >= frame_len_r - MIN_LENGTH) begin
                  phase_nxt = PH_CHECK;
                end
              end
              PH_CHECK: begin
                res_valid = 1'b1;
                res       = mk_status((b != ~sum_r) ? STAT_CHECKSUM : STAT_OK, err_byte_r);
                phase_nxt = PH_IDLE;
              end
              default: begin
                phase_nxt = PH_IDLE;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hdr_cnt_r   <= 2'd0;
      frame_len_r <= 8'd0;
      err_byte_r  <= 8'd0;
      sum_r       <= 8'd0;
      pay_idx_r   <= 8'd0;
      ticks_r     <= 16'd0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      frame_len_r <= frame_len_nxt;
      err_byte_r  <= err_byte_nxt;
      sum_r       <= sum_nxt;
      pay_idx_r   <= pay_idx_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

endmodule

### src/servo_status_frame_receiver.sv
// ----------------------------------------------------------------------------
// servo_status_frame_receiver
// Parses a servo status reply from a byte/tick/arm stream into payload bytes
// and one closing status result per armed frame.
// ----------------------------------------------------------------------------
//  Channel | Ports                         | Transfer when
//  --------+-------------------------------+------------------------------
//  input   | in_valid, in_ready, in_data   | in_valid && in_ready
//  result  | out_valid, out_ready, out_data| out_valid && out_ready
//  config  | cfg_we, cfg_index, cfg_wdata  | cfg_we
//
// Items flow one per cycle while the result is not stalled; an item that
// yields a result passes the input register, then the step logic into the
// result register, before result valid rises.
// Reset (synchronous, rst_n low) clears the frame state to idle, empties both
// registers and loads the register defaults (id 1, timeout 1000, keep 8).
// A stalled result holds the step; the input register then fills and
// in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_status_frame_receiver
  import ssfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t      cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      advance;
  logic      step_en;
  logic      res_valid;
  out_item_t res;

  // Step the held item whenever the result slot is free or being drained.
  assign advance  = !out_valid_r || out_ready;
  assign step_en  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Configuration registers: write immediately, ignore unused index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.servo_id      <= RST_SERVO_ID;
      cfg_r.timeout_ticks <= RST_TIMEOUT;
      cfg_r.keep_len      <= RST_KEEP_LEN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SERVO_ID: cfg_r.servo_id      <= cfg_wdata[7:0];
        CFG_TIMEOUT:  cfg_r.timeout_ticks <= cfg_wdata;
        CFG_KEEP_LEN: cfg_r.keep_len      <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: load on transfer, drop once stepped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  ssfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: advance on free slot, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_en && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_item_r <= res;
    end
  end

endmodule

### src/ssfr_checker.sv
// ----------------------------------------------------------------------------
// ssfr_checker
// Port-level checks of the servo status frame receiver, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "servo_status_frame_receiver_macros.svh"

module ssfr_checker
  import ssfr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input out_item_t  out_data
);

  logic out_stall;
  logic pay_shown;
  logic pay_status_ok;
  logic stat_shown;
  logic stat_fields_ok;

  assign out_stall      = out_valid && !out_ready;
  assign pay_shown      = out_valid && !out_data.last;
  assign pay_status_ok  = out_data.status == STAT_OK;
  assign stat_shown     = out_valid && out_data.last;
  assign stat_fields_ok = out_data.data == 8'd0 && out_data.index == 8'd0 &&
                          out_data.status <= STAT_TIMEOUT;

  `SSFR_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled result moved")

  `SSFR_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "in_ready low with no result")

  `SSFR_ASSERT_NOW(a_payload_fields, pay_shown, pay_status_ok, "payload result carries a status")

  `SSFR_ASSERT_NOW(a_status_fields, stat_shown, stat_fields_ok, "bad status result fields")

endmodule

bind servo_status_frame_receiver ssfr_checker u_ssfr_checker (.*);
